// ----- src/qos_rules_ie_parser_core_defines.svh -----
// ----------------------------------------------------------------------------
// QoS rules IE parser - assertion macros
// Shared property wrappers for the checker; clocked on clk_i, reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef QOS_RULES_IE_PARSER_CORE_DEFINES_SVH
`define QOS_RULES_IE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define QRP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qrp: property violated");

// Next-cycle implication.
`define QRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qrp: property violated");

`endif

// ----- src/qrp_pkg.sv -----
// ----------------------------------------------------------------------------
// QoS rules IE parser - package
// Word types, field kinds, error codes, parse phases and sizing constants.
// ----------------------------------------------------------------------------
package qrp_pkg;

  localparam int unsigned MaxRules = 256;
  localparam logic [8:0]  MaxRulesW = 9'(MaxRules);

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegExpectedIei  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegBufferLength = 1'b1;

  localparam logic [3:0] KindIei      = 4'd0;
  localparam logic [3:0] KindLenHigh  = 4'd1;
  localparam logic [3:0] KindLen      = 4'd2;
  localparam logic [3:0] KindRuleId   = 4'd3;
  localparam logic [3:0] KindRlenHigh = 4'd4;
  localparam logic [3:0] KindRlen     = 4'd5;
  localparam logic [3:0] KindFlags    = 4'd6;
  localparam logic [3:0] KindFhead    = 4'd7;
  localparam logic [3:0] KindClen     = 4'd8;
  localparam logic [3:0] KindContent  = 4'd9;
  localparam logic [3:0] KindPrec     = 4'd10;
  localparam logic [3:0] KindQfi      = 4'd11;
  localparam logic [3:0] KindIgnored  = 4'd12;

  localparam logic [1:0] ErrNone   = 2'd0;
  localparam logic [1:0] ErrIei    = 2'd1;
  localparam logic [1:0] ErrLength = 2'd2;

  typedef enum logic [3:0] {
    PhFirst   = 4'd0,
    PhLenHi   = 4'd1,
    PhLenLo   = 4'd2,
    PhRuleId  = 4'd3,
    PhRlenHi  = 4'd4,
    PhRlenLo  = 4'd5,
    PhFlags   = 4'd6,
    PhFhead   = 4'd7,
    PhClen    = 4'd8,
    PhContent = 4'd9,
    PhPrec    = 4'd10,
    PhQfi     = 4'd11,
    PhSurplus = 4'd12,
    PhDone    = 4'd13
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_element;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  field_kind;
    logic [15:0] value_main;
    logic [1:0]  value_bit;
    logic [3:0]  value_nibble;
    logic [7:0]  rule_index;
    logic [3:0]  filter_index;
    logic [1:0]  error_code;
    logic        end_of_element;
  } out_word_t;

  // Byte with its bit fields already split out by the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       zero;
    logic [2:0] op;
    logic       dqr;
    logic [3:0] nib;
    logic [1:0] dir;
    logic [5:0] qfi;
    logic       seg;
  } item_t;

endpackage

// ----- src/qrp_front.sv -----
// ----------------------------------------------------------------------------
// QoS rules IE parser - front end
// Accepts input words and splits each byte into its candidate bit fields.
// ----------------------------------------------------------------------------
module qrp_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  qrp_pkg::in_word_t in_word_i,
  input  logic              full_i,
  output logic              push_o,
  output qrp_pkg::item_t    item_o
);
  import qrp_pkg::*;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o.data  = in_word_i.in_byte;
    item_o.start = in_word_i.start_of_element;
    item_o.zero  = (in_word_i.in_byte == 8'd0);
    item_o.op    = in_word_i.in_byte[7:5];
    item_o.dqr   = in_word_i.in_byte[4];
    item_o.nib   = in_word_i.in_byte[3:0];
    item_o.dir   = in_word_i.in_byte[5:4];
    item_o.qfi   = in_word_i.in_byte[5:0];
    item_o.seg   = in_word_i.in_byte[6];
  end

endmodule

// ----- src/qrp_queue.sv -----
// ----------------------------------------------------------------------------
// QoS rules IE parser - decoupling queue
// Small FIFO of classified bytes between the front end and the parser.
// ----------------------------------------------------------------------------
module qrp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  qrp_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           avail_o,
  output qrp_pkg::item_t item_o
);
  import qrp_pkg::*;

  item_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign avail_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- src/qrp_back.sv -----
// ----------------------------------------------------------------------------
// QoS rules IE parser - back end
// Parse state machine, configuration registers and the output register.
// ----------------------------------------------------------------------------
module qrp_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [qrp_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [qrp_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                             avail_i,
  input  qrp_pkg::item_t                   item_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output qrp_pkg::out_word_t               out_word_o
);
  import qrp_pkg::*;

  logic [7:0]  expected_iei_q;
  logic [15:0] buffer_length_q;

  phase_e      phase_q, phase_d;
  logic [15:0] bytes_consumed_q, bytes_consumed_d;
  logic [15:0] element_length_q, element_length_d;
  logic [7:0]  length_high_q, length_high_d;
  logic [7:0]  current_rule_q, current_rule_d;
  logic [3:0]  current_filter_q, current_filter_d;
  logic [3:0]  filters_in_rule_q, filters_in_rule_d;
  logic [7:0]  content_left_q, content_left_d;
  logic [1:0]  error_latched_q, error_latched_d;
  logic [7:0]  rule_len_high_q, rule_len_high_d;

  logic        out_valid_q;
  out_word_t   out_q;
  out_word_t   res;

  logic        restart;
  logic        iei_en;
  logic        iei_bad;
  phase_e      eff_phase;
  logic        is_body;
  logic        body_last;
  logic [15:0] consumed_inc;
  logic [3:0]  filter_inc;
  phase_e      filter_next;
  logic [7:0]  content_dec;
  logic [15:0] hdr_len;
  logic [15:0] avail_len;
  logic [15:0] elen_full;
  logic        len_bad;
  logic        rule_last;

  assign pop_o = avail_i && (!out_valid_q || !out_stall_i);

  assign restart      = item_i.start || (phase_q == PhFirst);
  assign iei_en       = (expected_iei_q != 8'd0);
  assign iei_bad      = (item_i.data != expected_iei_q);
  assign eff_phase    = restart ? PhLenHi : phase_q;
  assign is_body      = !restart && (phase_q inside {[PhRuleId:PhSurplus]});
  assign consumed_inc = bytes_consumed_q + 16'd1;
  assign body_last    = (consumed_inc >= element_length_q);
  assign filter_inc   = current_filter_q + 4'd1;
  assign filter_next  = (filter_inc >= filters_in_rule_q) ? PhPrec : PhFhead;
  assign content_dec  = content_left_q - 8'd1;
  assign hdr_len      = iei_en ? 16'd3 : 16'd2;
  assign avail_len    = (buffer_length_q > hdr_len) ? buffer_length_q - hdr_len : 16'd0;
  assign elen_full    = {length_high_q, item_i.data};
  assign len_bad      = (elen_full > avail_len);
  assign rule_last    = ((9'(current_rule_q) + 9'd1) >= MaxRulesW);

  // Next parse state.
  always_comb begin
    phase_d           = phase_q;
    bytes_consumed_d  = bytes_consumed_q;
    element_length_d  = element_length_q;
    length_high_d     = length_high_q;
    current_rule_d    = current_rule_q;
    current_filter_d  = current_filter_q;
    filters_in_rule_d = filters_in_rule_q;
    content_left_d    = content_left_q;
    error_latched_d   = error_latched_q;
    rule_len_high_d   = rule_len_high_q;

    if (restart) begin
      bytes_consumed_d  = '0;
      element_length_d  = '0;
      length_high_d     = '0;
      current_rule_d    = '0;
      current_filter_d  = '0;
      filters_in_rule_d = '0;
      content_left_d    = '0;
      error_latched_d   = ErrNone;
      rule_len_high_d   = '0;
    end

    if (restart && iei_en) begin
      if (iei_bad) begin
        error_latched_d = ErrIei;
        phase_d         = PhDone;
      end else begin
        phase_d = PhLenHi;
      end
    end else begin
      case (eff_phase)
        PhLenHi: begin
          length_high_d = item_i.data;
          phase_d       = PhLenLo;
        end
        PhLenLo: begin
          element_length_d = elen_full;
          if (len_bad) begin
            error_latched_d = ErrLength;
            phase_d         = PhDone;
          end else if (elen_full == 16'd0) begin
            phase_d = PhDone;
          end else begin
            phase_d = PhRuleId;
          end
        end
        PhRuleId: phase_d = PhRlenHi;
        PhRlenHi: begin
          rule_len_high_d = item_i.data;
          phase_d         = PhRlenLo;
        end
        PhRlenLo: phase_d = PhFlags;
        PhFlags: begin
          filters_in_rule_d = item_i.nib;
          current_filter_d  = '0;
          phase_d           = (item_i.nib == 4'd0) ? PhPrec : PhFhead;
        end
        PhFhead: phase_d = PhClen;
        PhClen: begin
          content_left_d = item_i.data;
          if (item_i.zero) begin
            current_filter_d = filter_inc;
            phase_d          = filter_next;
          end else begin
            phase_d = PhContent;
          end
        end
        PhContent: begin
          content_left_d = content_dec;
          if (content_dec == 8'd0) begin
            current_filter_d = filter_inc;
            phase_d          = filter_next;
          end
        end
        PhPrec: phase_d = PhQfi;
        PhQfi: begin
          if (rule_last) begin
            phase_d = PhSurplus;
          end else begin
            current_rule_d = current_rule_q + 8'd1;
            phase_d        = PhRuleId;
          end
          current_filter_d  = '0;
          filters_in_rule_d = '0;
        end
        default: ;
      endcase

      if (is_body) begin
        bytes_consumed_d = consumed_inc;
        if (body_last) begin
          phase_d = PhDone;
        end
      end
    end
  end

  // Result word for the byte at the queue head.
  always_comb begin
    res            = '0;
    res.field_kind = KindIgnored;
    if (restart && iei_en) begin
      res.field_kind = KindIei;
      res.value_main = 16'(item_i.data);
      if (iei_bad) begin
        res.error_code     = ErrIei;
        res.end_of_element = 1'b1;
      end
    end else begin
      case (eff_phase)
        PhLenHi: begin
          res.field_kind = KindLenHigh;
          res.value_main = 16'(item_i.data);
        end
        PhLenLo: begin
          res.field_kind = KindLen;
          res.value_main = elen_full;
          if (len_bad) begin
            res.error_code     = ErrLength;
            res.end_of_element = 1'b1;
          end else if (elen_full == 16'd0) begin
            res.end_of_element = 1'b1;
          end
        end
        PhDone: res.error_code = error_latched_q;
        PhRuleId: begin
          res.field_kind = KindRuleId;
          res.value_main = 16'(item_i.data);
          res.rule_index = current_rule_q;
        end
        PhRlenHi: begin
          res.field_kind = KindRlenHigh;
          res.value_main = 16'(item_i.data);
          res.rule_index = current_rule_q;
        end
        PhRlenLo: begin
          res.field_kind = KindRlen;
          res.value_main = {rule_len_high_q, item_i.data};
          res.rule_index = current_rule_q;
        end
        PhFlags: begin
          res.field_kind   = KindFlags;
          res.value_main   = 16'(item_i.op);
          res.value_bit    = 2'(item_i.dqr);
          res.value_nibble = item_i.nib;
          res.rule_index   = current_rule_q;
        end
        PhFhead: begin
          res.field_kind   = KindFhead;
          res.value_main   = 16'(item_i.dir);
          res.value_nibble = item_i.nib;
          res.rule_index   = current_rule_q;
          res.filter_index = current_filter_q;
        end
        PhClen: begin
          res.field_kind   = KindClen;
          res.value_main   = 16'(item_i.data);
          res.rule_index   = current_rule_q;
          res.filter_index = current_filter_q;
        end
        PhContent: begin
          res.field_kind   = KindContent;
          res.value_main   = 16'(item_i.data);
          res.rule_index   = current_rule_q;
          res.filter_index = current_filter_q;
        end
        PhPrec: begin
          res.field_kind = KindPrec;
          res.value_main = 16'(item_i.data);
          res.rule_index = current_rule_q;
        end
        PhQfi: begin
          res.field_kind = KindQfi;
          res.value_main = 16'(item_i.qfi);
          res.value_bit  = 2'(item_i.seg);
          res.rule_index = current_rule_q;
        end
        default: ;
      endcase
      if (is_body && body_last) begin
        res.end_of_element = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_iei_q  <= 8'd0;
      buffer_length_q <= 16'hffff;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegExpectedIei:  expected_iei_q  <= cfg_data_i[7:0];
        RegBufferLength: buffer_length_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q           <= PhFirst;
      bytes_consumed_q  <= '0;
      element_length_q  <= '0;
      length_high_q     <= '0;
      current_rule_q    <= '0;
      current_filter_q  <= '0;
      filters_in_rule_q <= '0;
      content_left_q    <= '0;
      error_latched_q   <= ErrNone;
      rule_len_high_q   <= '0;
    end else if (pop_o) begin
      phase_q           <= phase_d;
      bytes_consumed_q  <= bytes_consumed_d;
      element_length_q  <= element_length_d;
      length_high_q     <= length_high_d;
      current_rule_q    <= current_rule_d;
      current_filter_q  <= current_filter_d;
      filters_in_rule_q <= filters_in_rule_d;
      content_left_q    <= content_left_d;
      error_latched_q   <= error_latched_d;
      rule_len_high_q   <= rule_len_high_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- src/qos_rules_ie_parser_core.sv -----
// ----------------------------------------------------------------------------
// QoS rules IE parser core
// Labels each byte of a QoS rules information element with its field.
// ----------------------------------------------------------------------------
//
//   channel  | handshake               | word
//   ---------+-------------------------+------------------------------------
//   input    | in_valid_i / in_stall_o | in_word_i   (in_byte, start flag)
//   output   | out_valid_o/out_stall_i | out_word_o  (kind, values, indices)
//   config   | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One word per cycle sustained while the output is not stalled: the parser
// advances its phase once per byte. A word accepted at the input is written
// into the four-entry queue and then registered in the output register
// before it reaches the output. Reset puts the parser at the first byte of
// an element and clears config to no IEI and a full buffer. Input stall
// rises only when the queue is full, which follows a stall on the output side.
//
module qos_rules_ie_parser_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  qrp_pkg::in_word_t            in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output qrp_pkg::out_word_t           out_word_o,
  input  logic                         cfg_we_i,
  input  logic [qrp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [qrp_pkg::CfgDataW-1:0] cfg_data_i
);
  import qrp_pkg::*;

  // Front end to queue.
  logic  push;
  logic  full;
  item_t push_item;

  // Queue to parser.
  logic  avail;
  logic  pop;
  item_t head_item;

  // Accept words and split each byte into its candidate fields.
  qrp_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  // Decouple: hold classified bytes while the parser output is stalled.
  qrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .avail_o (avail),
    .item_o  (head_item)
  );

  // Advance the parse phase and register one result per popped byte.
  qrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .avail_i     (avail),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- src/qrp_checker.sv -----
// ----------------------------------------------------------------------------
// QoS rules IE parser - port checker
// Checks output words against the element grammar; bound to the top level.
// ----------------------------------------------------------------------------
`include "qos_rules_ie_parser_core_defines.svh"

module qrp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input qrp_pkg::out_word_t out_word_o
);
  import qrp_pkg::*;

  `QRP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  `QRP_ASSERT_NOW(a_kind_range, out_valid_o, out_word_o.field_kind <= KindIgnored)

  `QRP_ASSERT_NOW(a_iei_err_kind, out_valid_o && out_word_o.error_code == ErrIei, out_word_o.field_kind == KindIei || out_word_o.field_kind == KindIgnored)

  `QRP_ASSERT_NOW(a_len_err_kind, out_valid_o && out_word_o.error_code == ErrLength, out_word_o.field_kind == KindLen || out_word_o.field_kind == KindIgnored)

  `QRP_ASSERT_NOW(a_filter_idx_kind, out_valid_o && out_word_o.filter_index != 4'd0, out_word_o.field_kind == KindFhead || out_word_o.field_kind == KindClen || out_word_o.field_kind == KindContent)

endmodule

bind qos_rules_ie_parser_core qrp_checker u_qrp_checker (.*);

// ----- tb/qos_rules_ie_parser_core_checker.sv -----
// ----------------------------------------------------------------------------
// QoS rules IE parser - checker
// Watches the input, output and config ports of the parser, predicts the
// label of every accepted byte and compares each output word field by field.
// ----------------------------------------------------------------------------
module qos_rules_ie_parser_core_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  qrp_pkg::in_word_t            in_word_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  qrp_pkg::out_word_t           out_word_i,
  input  logic                         cfg_we_i,
  input  logic [qrp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [qrp_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  import qrp_pkg::*;

  // Shadow of the config registers.
  logic [7:0]  iei_reg;
  logic [15:0] buflen_reg;

  // Shadow of the parser state.
  phase_e      phase;
  logic [15:0] consumed;
  logic [15:0] ie_len;
  logic [7:0]  len_hi;
  logic [7:0]  rlen_hi;
  logic [7:0]  rule;
  logic [3:0]  filt;
  logic [3:0]  nfilt;
  logic [7:0]  content_left;
  logic [1:0]  err_latched;

  out_word_t   labels_q[$];
  out_word_t   want;

  // Advance to the next filter of the rule, or to precedence after the last.
  function automatic phase_e next_filter();
    filt = filt + 4'd1;
    return (filt >= nfilt) ? PhPrec : PhFhead;
  endfunction

  function automatic out_word_t label_byte(in_word_t w);
    out_word_t   o;
    phase_e      nxt;
    logic [7:0]  b;
    logic [15:0] hdr;
    logic [15:0] avail;
    b = w.in_byte;
    o = '0;
    o.field_kind = KindIgnored;
    if (w.start_of_element || phase == PhFirst) begin
      consumed     = '0;
      ie_len       = '0;
      len_hi       = '0;
      rlen_hi      = '0;
      rule         = '0;
      filt         = '0;
      nfilt        = '0;
      content_left = '0;
      err_latched  = ErrNone;
      phase        = PhLenHi;
      if (iei_reg != 8'd0) begin
        o.field_kind = KindIei;
        o.value_main = {8'd0, b};
        if (b != iei_reg) begin
          err_latched      = ErrIei;
          o.error_code     = ErrIei;
          o.end_of_element = 1'b1;
          phase            = PhDone;
        end
        return o;
      end
    end

    case (phase)
      PhLenHi: begin
        o.field_kind = KindLenHigh;
        o.value_main = {8'd0, b};
        len_hi       = b;
        phase        = PhLenLo;
        return o;
      end
      PhLenLo: begin
        hdr          = (iei_reg != 8'd0) ? 16'd3 : 16'd2;
        avail        = (buflen_reg > hdr) ? buflen_reg - hdr : 16'd0;
        ie_len       = {len_hi, b};
        o.field_kind = KindLen;
        o.value_main = ie_len;
        if (ie_len > avail) begin
          err_latched      = ErrLength;
          o.error_code     = ErrLength;
          o.end_of_element = 1'b1;
          phase            = PhDone;
        end else if (ie_len == 16'd0) begin
          o.end_of_element = 1'b1;
          phase            = PhDone;
        end else begin
          phase = PhRuleId;
        end
        return o;
      end
      PhDone: begin
        o.error_code = err_latched;
        return o;
      end
      default: ;
    endcase

    // Body byte: label it by where the rule decoding stands.
    o.rule_index = rule;
    nxt = phase;
    case (phase)
      PhRuleId: begin
        o.field_kind = KindRuleId;
        o.value_main = {8'd0, b};
        nxt          = PhRlenHi;
      end
      PhRlenHi: begin
        o.field_kind = KindRlenHigh;
        o.value_main = {8'd0, b};
        rlen_hi      = b;
        nxt          = PhRlenLo;
      end
      PhRlenLo: begin
        o.field_kind = KindRlen;
        o.value_main = {rlen_hi, b};
        nxt          = PhFlags;
      end
      PhFlags: begin
        o.field_kind   = KindFlags;
        o.value_main   = {13'd0, b[7:5]};
        o.value_bit    = {1'b0, b[4]};
        o.value_nibble = b[3:0];
        nfilt          = b[3:0];
        filt           = '0;
        nxt            = (b[3:0] == 4'd0) ? PhPrec : PhFhead;
      end
      PhFhead: begin
        o.field_kind   = KindFhead;
        o.filter_index = filt;
        o.value_main   = {14'd0, b[5:4]};
        o.value_nibble = b[3:0];
        nxt            = PhClen;
      end
      PhClen: begin
        o.field_kind   = KindClen;
        o.filter_index = filt;
        o.value_main   = {8'd0, b};
        content_left   = b;
        nxt            = (b == 8'd0) ? next_filter() : PhContent;
      end
      PhContent: begin
        o.field_kind   = KindContent;
        o.filter_index = filt;
        o.value_main   = {8'd0, b};
        content_left   = content_left - 8'd1;
        nxt            = (content_left == 8'd0) ? next_filter() : PhContent;
      end
      PhPrec: begin
        o.field_kind = KindPrec;
        o.value_main = {8'd0, b};
        nxt          = PhQfi;
      end
      PhQfi: begin
        o.field_kind = KindQfi;
        o.value_main = {10'd0, b[5:0]};
        o.value_bit  = {1'b0, b[6]};
        if ({1'b0, rule} + 9'd1 >= MaxRulesW) begin
          nxt = PhSurplus;
        end else begin
          rule = rule + 8'd1;
          nxt  = PhRuleId;
        end
        filt  = '0;
        nfilt = '0;
      end
      default: begin
        o.field_kind = KindIgnored;
        o.rule_index = '0;
        nxt          = PhSurplus;
      end
    endcase
    consumed = consumed + 16'd1;
    if (consumed >= ie_len) begin
      o.end_of_element = 1'b1;
      nxt              = PhDone;
    end
    phase = nxt;
    return o;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iei_reg      = 8'd0;
      buflen_reg   = 16'hffff;
      phase        = PhFirst;
      consumed     = '0;
      ie_len       = '0;
      len_hi       = '0;
      rlen_hi      = '0;
      rule         = '0;
      filt         = '0;
      nfilt        = '0;
      content_left = '0;
      err_latched  = ErrNone;
      labels_q.delete();
      pending_o    = 0;
    end else begin
      // Compare before predicting: a word cannot come out the edge it enters.
      if (out_valid_i && !out_stall_i) begin
        if (labels_q.size() == 0) begin
          $display("%0t: unexpected output word: kind %0d value %0d", $time,
                   out_word_i.field_kind, out_word_i.value_main);
          fail_count_o++;
        end else begin
          want = labels_q.pop_front();
          check_field("field_kind", want.field_kind, out_word_i.field_kind);
          check_field("value_main", want.value_main, out_word_i.value_main);
          check_field("value_bit", want.value_bit, out_word_i.value_bit);
          check_field("value_nibble", want.value_nibble, out_word_i.value_nibble);
          check_field("rule_index", want.rule_index, out_word_i.rule_index);
          check_field("filter_index", want.filter_index, out_word_i.filter_index);
          check_field("error_code", want.error_code, out_word_i.error_code);
          check_field("end_of_element", want.end_of_element, out_word_i.end_of_element);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegExpectedIei:  iei_reg = cfg_data_i[7:0];
          RegBufferLength: buflen_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) labels_q.push_back(label_byte(in_word_i));
      pending_o = labels_q.size();
    end
  end

endmodule

// ----- tb/qos_rules_ie_parser_core_tb.sv -----
// ----------------------------------------------------------------------------
// QoS rules IE parser - testbench top
// Feeds directed and random QoS rules elements byte by byte through the
// parser under changing config and back-pressure; the checker labels every
// byte on its own and this top reports the verdict.
// ----------------------------------------------------------------------------
module qos_rules_ie_parser_core_tb;
  import qrp_pkg::*;

  logic                clk_i;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_word_t            in_word   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_word;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int fail_count;
  int pending;

  // Knobs for the sender and the receiver.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_seq      = 0;   // bump to request a long receiver hold-off
  int hold_seen     = 0;
  int hold_left     = 0;
  int words_sent    = 0;

  logic [7:0] iei_now = 8'd0;   // IEI currently programmed, used to build headers
  in_word_t   word_q[$];

  qos_rules_ie_parser_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  qos_rules_ie_parser_core_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: stall at random, or hold off for a long stretch on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = 48;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Guard against a hung run.
  initial begin
    #4800000;
    $display("qos_rules_ie_parser_core_tb: FAIL");
    $finish;
  end

  task automatic push(logic [7:0] b, logic s);
    word_q.push_back(in_word_t'{in_byte: b, start_of_element: s});
  endtask

  // Offer every queued word in turn; drop valid only during random idle
  // cycles, hold the word steady while the parser stalls.
  task automatic send_queue();
    while (word_q.size() != 0) begin
      @(negedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(negedge clk_i);
      end
      in_valid <= 1'b1;
      in_word  <= word_q.pop_front();
      @(posedge clk_i);
      while (in_stall) @(posedge clk_i);
      words_sent++;
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Drain the parser, then reprogram it; junk in the upper IEI bits must
  // be ignored.
  task automatic set_config(logic [7:0] iei, logic [15:0] blen);
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (pending == 0);
    write_reg(RegExpectedIei, {8'($urandom), iei});
    write_reg(RegBufferLength, blen);
    iei_now = iei;
  endtask

  initial begin : stimulus
    logic [7:0]  body[$];
    logic [15:0] ie_len;
    logic [15:0] rlen;
    logic        s;
    int          rule_start;
    int          nf;
    int          clen;
    int          target;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part ----
    set_config(8'h00, 16'hffff);

    // First byte after reset opens an element even without the start flag.
    // One rule with extreme values, two filters, the first with no content.
    push(8'h00, 1'b0); push(8'h0b, 1'b0);
    push(8'hff, 1'b0); push(8'hff, 1'b0); push(8'hff, 1'b0);
    push(8'hf2, 1'b0);
    push(8'hff, 1'b0); push(8'h00, 1'b0);
    push(8'h30, 1'b0); push(8'h01, 1'b0); push(8'hab, 1'b0);
    push(8'hff, 1'b0); push(8'hff, 1'b0);
    push(8'h5a, 1'b0);                       // idle byte after the element
    push(8'h00, 1'b1); push(8'h00, 1'b0);    // zero length
    // Restart inside a rule, then a rule cut short by the IE length.
    push(8'h00, 1'b1); push(8'h05, 1'b0); push(8'h07, 1'b0);
    push(8'h00, 1'b1); push(8'h02, 1'b0); push(8'h01, 1'b0); push(8'h00, 1'b0);
    send_queue();

    // Empty buffer: any nonzero length overflows; idle repeats the error.
    set_config(8'h00, 16'h0000);
    push(8'h00, 1'b1); push(8'h01, 1'b0); push(8'h00, 1'b0);
    send_queue();

    // IEI mismatch, then a length exactly at the limit and one past it.
    set_config(8'hff, 16'hffff);
    push(8'h00, 1'b1); push(8'h11, 1'b0);
    push(8'hff, 1'b1); push(8'hff, 1'b0); push(8'hfc, 1'b0);
    push(8'hff, 1'b1); push(8'hff, 1'b0); push(8'hfd, 1'b0);
    send_queue();

    // ---- random part ----
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 32; stall_pct = 68; end
        1: begin send_idle_pct = 68; stall_pct = 32; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase

      for (int k = 0; k < 3; k++) begin
        case (k)
          0: set_config(8'h00, (mode == 0) ? 16'hffff : 16'($urandom));
          1: set_config(8'($urandom_range(1, 255)), 16'($urandom_range(0, 60)));
          default: set_config((mode == 1) ? 8'hff : 8'h01,
                              (mode == 2) ? 16'd3 : 16'($urandom_range(40, 400)));
        endcase

        // Back up the parser while the sender keeps offering words.
        if (mode == 0 && k == 1) hold_seq++;

        target = words_sent + 60;
        while (words_sent < target) begin
          if ($urandom_range(0, 7) == 0) begin
            // Noise: random bytes, some of them restarting the parser.
            repeat ($urandom_range(1, 6)) push(8'($urandom), ($urandom_range(0, 3) == 0));
          end else begin
            // Well-formed rules with random content.
            body.delete();
            repeat ($urandom_range(1, 4)) begin
              rule_start = body.size();
              body.push_back(8'($urandom));
              body.push_back(8'h00);
              body.push_back(8'h00);
              nf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
              body.push_back({3'($urandom), 1'($urandom), 4'(nf)});
              repeat (nf) begin
                body.push_back(8'($urandom));
                clen = ($urandom_range(0, 49) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 5);
                body.push_back(8'(clen));
                repeat (clen) body.push_back(8'($urandom));
              end
              body.push_back(8'($urandom));
              body.push_back(8'($urandom));
              rlen = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'(body.size() - rule_start - 3);
              body[rule_start + 1] = rlen[15:8];
              body[rule_start + 2] = rlen[7:0];
            end
            // Mostly the exact size; sometimes cut short or far too long.
            case ($urandom_range(0, 9))
              7:       ie_len = 16'($urandom_range(0, body.size()));
              8:       ie_len = 16'($urandom);
              default: ie_len = 16'(body.size());
            endcase
            s = ($urandom_range(0, 15) != 0);
            if (iei_now != 8'd0) begin
              push(($urandom_range(0, 9) == 0) ? 8'($urandom) : iei_now, s);
              s = 1'b0;
            end
            push(ie_len[15:8], s);
            push(ie_len[7:0], 1'b0);
            foreach (body[i]) if (i < ie_len) push(body[i], 1'b0);
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
              push(8'($urandom), 1'b0);
          end
          send_queue();
        end
      end
    end

    // Stop offering words and let every label come out.
    @(negedge clk_i);
    in_valid <= 1'b0;
    stall_pct = 0;
    wait (pending == 0);
    repeat (8) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("qos_rules_ie_parser_core_tb: PASS");
    end else begin
      $display("qos_rules_ie_parser_core_tb: FAIL");
    end
    $finish;
  end

endmodule
